### hw/rtl/rdqs_pkg.sv
// Shared types and codes for the ready and device queue scheduler.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package rdqs_pkg;

  localparam int unsigned ENTRY_W = 24;

  localparam logic [7:0] THRESHOLD_RST = 8'd7;
  localparam logic [2:0] ADDR_THRESHOLD = 3'd0;

  localparam logic [1:0] REQ_ADMIT     = 2'd0;
  localparam logic [1:0] REQ_INTERRUPT = 2'd1;
  localparam logic [1:0] REQ_RETURN    = 2'd2;
  localparam logic [1:0] REQ_FINISH    = 2'd3;

  localparam logic SEL_FIFO = 1'b0;
  localparam logic SEL_PRIO = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [1:0] DEST_FIFO   = 2'd0;
  localparam logic [1:0] DEST_PRIO   = 2'd1;
  localparam logic [1:0] DEST_DEVICE = 2'd2;
  localparam logic [1:0] DEST_DROP   = 2'd3;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT
  } cell_op_e;

  typedef enum logic [1:0] {
    Q_IDLE,
    Q_PUSH,
    Q_POP,
    Q_SORT
  } queue_op_e;

  typedef struct packed {
    logic [7:0] id;
    logic [7:0] tm;
    logic [7:0] pr;
  } entry_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       queue_sel;
    logic [7:0] proc_id;
    logic [7:0] burst_time;
    logic [7:0] prio_level;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] out_id;
    logic [7:0] out_time;
    logic [7:0] out_prio;
    logic [1:0] dest_queue;
    logic [4:0] fifo_count;
    logic [4:0] prio_count;
    logic [4:0] device_count;
  } rsp_t;

endpackage

### hw/rtl/ready_and_device_queue_scheduler_core.sv
// Top level of the ready and device queue scheduler: request decode, three cell-chain
// queues, APB threshold register and result register. Depends on rdqs_pkg and rdqs_queue.
`timescale 1ns / 1ps

// A request is taken through start while busy is low; busy is then high for one cycle in
// which the request is decoded from a register, and at the edge that ends that cycle all
// three cell chains shift, load or insert in parallel and the result word is registered.
// rsp_valid_o is high for exactly the cycle after that and the receiver cannot stall it,
// so a new request may be started as soon as busy is low again. The
// chains keep the priority queue sorted by descending priority, a newcomer going ahead of
// equal priorities. time_threshold sits at byte address 0 and resets to 7; write it only
// while idle.

module ready_and_device_queue_scheduler_core #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  rdqs_pkg::req_t    req_i,
  output logic              rsp_valid_o,
  output rdqs_pkg::rsp_t    rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned DEV_W = rdqs_pkg::ENTRY_W + 1;

  logic               busy_q;
  rdqs_pkg::req_t     req_q;
  logic               rsp_valid_q;
  rdqs_pkg::rsp_t     rsp_d, rsp_q;
  logic [7:0]         thr_d, thr_q;

  rdqs_pkg::queue_op_e fifo_op, prio_op, dev_op;
  logic [rdqs_pkg::ENTRY_W-1:0] fifo_head, prio_head, ready_new;
  logic [DEV_W-1:0]   dev_head, dev_new;
  logic [CW-1:0]      fifo_cnt, prio_cnt, dev_cnt;
  logic [CW-1:0]      fifo_nxt, prio_nxt, dev_nxt;
  logic               fifo_empty, prio_empty, dev_empty;
  logic               fifo_full, prio_full, dev_full;
  logic [CW+4:0]      fifo_ext, prio_ext, dev_ext;

  rdqs_pkg::entry_t   adm_e, dev_e, src_e;
  logic               dev_org, src_empty;
  logic [1:0]         st, dst;
  rdqs_pkg::entry_t   ent;

  assign adm_e     = '{id: req_q.proc_id, tm: req_q.burst_time, pr: req_q.prio_level};
  assign dev_e     = rdqs_pkg::entry_t'(dev_head[rdqs_pkg::ENTRY_W-1:0]);
  assign dev_org   = dev_head[rdqs_pkg::ENTRY_W];
  assign src_e     = (req_q.queue_sel == rdqs_pkg::SEL_PRIO) ?
                     rdqs_pkg::entry_t'(prio_head) : rdqs_pkg::entry_t'(fifo_head);
  assign src_empty = (req_q.queue_sel == rdqs_pkg::SEL_PRIO) ? prio_empty : fifo_empty;
  assign ready_new = (req_q.req_type == rdqs_pkg::REQ_RETURN) ? dev_e : adm_e;
  assign dev_new   = {req_q.queue_sel, src_e};

  always_comb begin
    fifo_op = rdqs_pkg::Q_IDLE;
    prio_op = rdqs_pkg::Q_IDLE;
    dev_op  = rdqs_pkg::Q_IDLE;
    st      = rdqs_pkg::ST_OK;
    dst     = rdqs_pkg::DEST_FIFO;
    ent     = '0;
    if (busy_q) begin
      unique case (req_q.req_type)
        rdqs_pkg::REQ_ADMIT: begin
          if (req_q.burst_time >= thr_q) begin
            if (fifo_full) begin
              st = rdqs_pkg::ST_FULL;
            end else begin
              fifo_op = rdqs_pkg::Q_PUSH;
              dst     = rdqs_pkg::DEST_FIFO;
              ent     = adm_e;
            end
          end else begin
            if (prio_full) begin
              st = rdqs_pkg::ST_FULL;
            end else begin
              prio_op = rdqs_pkg::Q_SORT;
              dst     = rdqs_pkg::DEST_PRIO;
              ent     = adm_e;
            end
          end
        end
        rdqs_pkg::REQ_INTERRUPT: begin
          if (src_empty) begin
            st = rdqs_pkg::ST_EMPTY;
          end else if (dev_full) begin
            st = rdqs_pkg::ST_FULL;
          end else begin
            dev_op = rdqs_pkg::Q_PUSH;
            if (req_q.queue_sel == rdqs_pkg::SEL_PRIO) begin
              prio_op = rdqs_pkg::Q_POP;
            end else begin
              fifo_op = rdqs_pkg::Q_POP;
            end
            dst = rdqs_pkg::DEST_DEVICE;
            ent = src_e;
          end
        end
        rdqs_pkg::REQ_RETURN: begin
          if (dev_empty) begin
            st = rdqs_pkg::ST_EMPTY;
          end else if (dev_org == rdqs_pkg::SEL_PRIO) begin
            if (prio_full) begin
              st = rdqs_pkg::ST_FULL;
            end else begin
              prio_op = rdqs_pkg::Q_SORT;
              dev_op  = rdqs_pkg::Q_POP;
              dst     = rdqs_pkg::DEST_PRIO;
              ent     = dev_e;
            end
          end else begin
            if (fifo_full) begin
              st = rdqs_pkg::ST_FULL;
            end else begin
              fifo_op = rdqs_pkg::Q_PUSH;
              dev_op  = rdqs_pkg::Q_POP;
              dst     = rdqs_pkg::DEST_FIFO;
              ent     = dev_e;
            end
          end
        end
        rdqs_pkg::REQ_FINISH: begin
          if (src_empty) begin
            st = rdqs_pkg::ST_EMPTY;
          end else begin
            if (req_q.queue_sel == rdqs_pkg::SEL_PRIO) begin
              prio_op = rdqs_pkg::Q_POP;
            end else begin
              fifo_op = rdqs_pkg::Q_POP;
            end
            dst = rdqs_pkg::DEST_DROP;
            ent = src_e;
          end
        end
        default: st = rdqs_pkg::ST_OK;
      endcase
    end
  end

  rdqs_queue #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (rdqs_pkg::ENTRY_W)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (fifo_op),
    .new_i       (ready_new),
    .head_o      (fifo_head),
    .count_o     (fifo_cnt),
    .count_nxt_o (fifo_nxt),
    .empty_o     (fifo_empty),
    .full_o      (fifo_full)
  );

  rdqs_queue #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (rdqs_pkg::ENTRY_W)
  ) u_prio (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (prio_op),
    .new_i       (ready_new),
    .head_o      (prio_head),
    .count_o     (prio_cnt),
    .count_nxt_o (prio_nxt),
    .empty_o     (prio_empty),
    .full_o      (prio_full)
  );

  rdqs_queue #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (DEV_W)
  ) u_dev (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (dev_op),
    .new_i       (dev_new),
    .head_o      (dev_head),
    .count_o     (dev_cnt),
    .count_nxt_o (dev_nxt),
    .empty_o     (dev_empty),
    .full_o      (dev_full)
  );

  assign fifo_ext = {5'b0, fifo_nxt};
  assign prio_ext = {5'b0, prio_nxt};
  assign dev_ext  = {5'b0, dev_nxt};

  assign rsp_d = '{
    status:       st,
    out_id:       ent.id,
    out_time:     ent.tm,
    out_prio:     ent.pr,
    dest_queue:   dst,
    fifo_count:   fifo_ext[4:0],
    prio_count:   prio_ext[4:0],
    device_count: dev_ext[4:0]
  };

  assign thr_d = (psel && penable && pwrite && (paddr == rdqs_pkg::ADDR_THRESHOLD)) ?
                 pwdata[7:0] : thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
      thr_q       <= rdqs_pkg::THRESHOLD_RST;
    end else begin
      busy_q      <= start && !busy_q;
      rsp_valid_q <= busy_q;
      thr_q       <= thr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy_q) begin
      req_q <= req_i;
    end
    if (busy_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign busy        = busy_q;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;
  assign pready      = 1'b1;
  assign prdata      = (paddr == rdqs_pkg::ADDR_THRESHOLD) ? {24'b0, thr_q} : 32'b0;

`ifndef SYNTHESIS
  a_start_to_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy ##1 rsp_valid_o)
    else $error("accepted request did not give a result word two cycles later");

  a_fail_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && (rsp_o.status != rdqs_pkg::ST_OK)) |->
      ((rsp_o.out_id == 8'd0) && (rsp_o.out_time == 8'd0) && (rsp_o.out_prio == 8'd0) &&
       (rsp_o.dest_queue == rdqs_pkg::DEST_FIFO)))
    else $error("failed request carries a nonzero entry");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fifo_cnt <= CW'(QUEUE_DEPTH)) && (prio_cnt <= CW'(QUEUE_DEPTH)) &&
    (dev_cnt <= CW'(QUEUE_DEPTH)))
    else $error("queue fill beyond depth");
`endif

endmodule

### hw/rtl/rdqs_cell.sv
// One storage cell of a queue chain: holds, loads a new word, or takes a neighbour's.
// Depends on rdqs_pkg.
`timescale 1ns / 1ps

module rdqs_cell #(
  parameter int unsigned WIDTH = 24
) (
  input  logic                 clk_i,
  input  rdqs_pkg::cell_op_e   op_i,
  input  logic [WIDTH-1:0]     left_i,
  input  logic [WIDTH-1:0]     right_i,
  input  logic [WIDTH-1:0]     load_i,
  output logic [WIDTH-1:0]     data_o
);

  logic [WIDTH-1:0] data_d, data_q;

  always_comb begin
    case (op_i)
      rdqs_pkg::CELL_LOAD:       data_d = load_i;
      rdqs_pkg::CELL_FROM_LEFT:  data_d = left_i;
      rdqs_pkg::CELL_FROM_RIGHT: data_d = right_i;
      default:                   data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

### hw/rtl/rdqs_queue.sv
// Queue built as a row of cells with a fill counter: tail push, head pop, sorted insert.
// Depends on rdqs_pkg and rdqs_cell.
`timescale 1ns / 1ps

module rdqs_queue #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rdqs_pkg::queue_op_e               op_i,
  input  logic [WIDTH-1:0]                  new_i,
  output logic [WIDTH-1:0]                  head_o,
  output logic [$clog2(DEPTH+1)-1:0]        count_o,
  output logic [$clog2(DEPTH+1)-1:0]        count_nxt_o,
  output logic                              empty_o,
  output logic                              full_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CW-1:0]    count_d, count_q;
  logic [WIDTH-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0] gt;
  logic [DEPTH-1:0] left_gt;
  rdqs_pkg::entry_t new_ent;

  assign new_ent = rdqs_pkg::entry_t'(new_i[rdqs_pkg::ENTRY_W-1:0]);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WIDTH-1:0]   left_w, right_w;
    rdqs_pkg::entry_t   cur_ent;
    rdqs_pkg::cell_op_e cop;

    assign cur_ent = rdqs_pkg::entry_t'(cell_data[i][rdqs_pkg::ENTRY_W-1:0]);
    assign gt[i]   = (CW'(i) < count_q) && (cur_ent.pr > new_ent.pr);

    if (i == 0) begin : g_first
      assign left_w     = '0;
      assign left_gt[i] = 1'b1;
    end else begin : g_inner
      assign left_w     = cell_data[i-1];
      assign left_gt[i] = gt[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid
      assign right_w = cell_data[i+1];
    end

    always_comb begin
      cop = rdqs_pkg::CELL_HOLD;
      case (op_i)
        rdqs_pkg::Q_PUSH: begin
          if (CW'(i) == count_q) begin
            cop = rdqs_pkg::CELL_LOAD;
          end
        end
        rdqs_pkg::Q_POP: cop = rdqs_pkg::CELL_FROM_RIGHT;
        rdqs_pkg::Q_SORT: begin
          if (!gt[i]) begin
            cop = left_gt[i] ? rdqs_pkg::CELL_LOAD : rdqs_pkg::CELL_FROM_LEFT;
          end
        end
        default: cop = rdqs_pkg::CELL_HOLD;
      endcase
    end

    rdqs_cell #(
      .WIDTH (WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .op_i    (cop),
      .left_i  (left_w),
      .right_i (right_w),
      .load_i  (new_i),
      .data_o  (cell_data[i])
    );
  end

  always_comb begin
    case (op_i) inside
      rdqs_pkg::Q_PUSH, rdqs_pkg::Q_SORT: count_d = count_q + CW'(1);
      rdqs_pkg::Q_POP:                    count_d = count_q - CW'(1);
      default:                            count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign head_o      = cell_data[0];
  assign count_o     = count_q;
  assign count_nxt_o = count_d;
  assign empty_o     = (count_q == '0);
  assign full_o      = (count_q == CW'(DEPTH));

endmodule
